FILE: hw/rtl/bsr_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the microprogram of the bridge adc reader
// no dependencies; used by bsr_seq, bsr_dp and the top level
package bsr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CNT_W       = 11;
  localparam int TO_W        = 25;
  localparam int HOLD_W      = 16;
  localparam int AVG_W       = 24;
  localparam int ST_W        = 2;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 2;
  localparam int CFG_W       = 25;
  localparam int PH_W        = 4;
  localparam int UPC_W       = 6;
  localparam int OP_W        = 4;
  localparam int JT_W        = 3;
  localparam int CND_W       = 4;
  localparam int SUM_W       = SAMPLE_BITS + CNT_W;
  localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  localparam logic [CNT_W-1:0]  CNT_MAX       = CNT_W'(1024);
  localparam logic [CNT_W-1:0]  CNT_RESET     = CNT_W'(1);
  localparam logic [TO_W-1:0]   TO_RESET      = TO_W'(23232323);
  localparam logic [HOLD_W-1:0] HOLD_RESET    = HOLD_W'(52);
  localparam logic [SAMPLE_BITS-1:0] WORD_MSB = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // register indexes
  localparam logic [IDX_W-1:0] REG_AVERAGE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_READY_TIMEOUT = 2'd1;
  localparam logic [IDX_W-1:0] REG_HOLD_TICKS    = 2'd2;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PDOWN = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_TIMEOUT = 2'd1;
  localparam logic [ST_W-1:0] ST_PIN_LOW = 2'd2;

  // status source in a control word
  localparam logic [1:0] SS_KEEP    = 2'd0;
  localparam logic [1:0] SS_TIMEOUT = 2'd1;
  localparam logic [1:0] SS_PIN     = 2'd2;

  // phases
  localparam logic [PH_W-1:0] PH_IDLE_LO  = 4'd0;
  localparam logic [PH_W-1:0] PH_IDLE_HI  = 4'd1;
  localparam logic [PH_W-1:0] PH_WAIT     = 4'd2;
  localparam logic [PH_W-1:0] PH_BIT_HI   = 4'd3;
  localparam logic [PH_W-1:0] PH_BIT_LO   = 4'd4;
  localparam logic [PH_W-1:0] PH_REL_HI   = 4'd5;
  localparam logic [PH_W-1:0] PH_REL_LO   = 4'd6;
  localparam logic [PH_W-1:0] PH_RST_HOLD = 4'd7;
  localparam logic [PH_W-1:0] PH_RST_REL  = 4'd8;
  localparam logic [PH_W-1:0] PH_PD_HOLD  = 4'd9;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
  localparam logic [OP_W-1:0] OP_START_READ = 4'd2;
  localparam logic [OP_W-1:0] OP_DEC_TO     = 4'd3;
  localparam logic [OP_W-1:0] OP_CLR_WORD   = 4'd4;
  localparam logic [OP_W-1:0] OP_SHIFT      = 4'd5;
  localparam logic [OP_W-1:0] OP_ACCUM      = 4'd6;
  localparam logic [OP_W-1:0] OP_LOAD_TO    = 4'd7;
  localparam logic [OP_W-1:0] OP_LOAD_HOLD  = 4'd8;
  localparam logic [OP_W-1:0] OP_DEC_HOLD   = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_INIT   = 4'd10;
  localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd11;
  localparam logic [OP_W-1:0] OP_DIV_OUT    = 4'd12;
  localparam logic [OP_W-1:0] OP_EMIT       = 4'd13;

  // jump types
  localparam logic [JT_W-1:0] J_NEXT = 3'd0;
  localparam logic [JT_W-1:0] J_GOTO = 3'd1;
  localparam logic [JT_W-1:0] J_IF   = 3'd2;
  localparam logic [JT_W-1:0] J_IFN  = 3'd3;
  localparam logic [JT_W-1:0] J_DISP = 3'd4;

  // jump conditions
  localparam logic [CND_W-1:0] C_NONE     = 4'd0;
  localparam logic [CND_W-1:0] C_IN_VALID = 4'd1;
  localparam logic [CND_W-1:0] C_DOUT_LOW = 4'd2;
  localparam logic [CND_W-1:0] C_TO_ZERO  = 4'd3;
  localparam logic [CND_W-1:0] C_BITS_FUL = 4'd4;
  localparam logic [CND_W-1:0] C_SAMP_END = 4'd5;
  localparam logic [CND_W-1:0] C_HOLD_ZER = 4'd6;
  localparam logic [CND_W-1:0] C_DIV_MORE = 4'd7;
  localparam logic [CND_W-1:0] C_OUT_BUSY = 4'd8;
  localparam logic [CND_W-1:0] C_CMD_READ = 4'd9;
  localparam logic [CND_W-1:0] C_CMD_HOLD = 4'd10;
  localparam logic [CND_W-1:0] C_CMD_RST  = 4'd11;
  localparam logic [CND_W-1:0] C_IDLE_HI  = 4'd12;
  localparam logic [CND_W-1:0] C_PH_RST   = 4'd13;

  // microprogram addresses
  localparam logic [UPC_W-1:0] A_FETCH   = 6'd0;
  localparam logic [UPC_W-1:0] A_DISP    = 6'd1;
  localparam logic [UPC_W-1:0] A_I0      = 6'd2;
  localparam logic [UPC_W-1:0] A_I1      = 6'd3;
  localparam logic [UPC_W-1:0] A_I2      = 6'd4;
  localparam logic [UPC_W-1:0] A_I3      = 6'd5;
  localparam logic [UPC_W-1:0] A_I_HI    = 6'd6;
  localparam logic [UPC_W-1:0] A_I_READ  = 6'd7;
  localparam logic [UPC_W-1:0] A_I_HOLD  = 6'd8;
  localparam logic [UPC_W-1:0] A_I_RST   = 6'd9;
  localparam logic [UPC_W-1:0] A_W0      = 6'd10;
  localparam logic [UPC_W-1:0] A_W1      = 6'd11;
  localparam logic [UPC_W-1:0] A_W2      = 6'd12;
  localparam logic [UPC_W-1:0] A_W3      = 6'd13;
  localparam logic [UPC_W-1:0] A_W_LOW   = 6'd14;
  localparam logic [UPC_W-1:0] A_W_FAIL  = 6'd15;
  localparam logic [UPC_W-1:0] A_B_HI    = 6'd16;
  localparam logic [UPC_W-1:0] A_B_LO    = 6'd17;
  localparam logic [UPC_W-1:0] A_B1      = 6'd18;
  localparam logic [UPC_W-1:0] A_B2      = 6'd19;
  localparam logic [UPC_W-1:0] A_B_FULL  = 6'd20;
  localparam logic [UPC_W-1:0] A_R_HI    = 6'd21;
  localparam logic [UPC_W-1:0] A_R_LO    = 6'd22;
  localparam logic [UPC_W-1:0] A_R1      = 6'd23;
  localparam logic [UPC_W-1:0] A_R2      = 6'd24;
  localparam logic [UPC_W-1:0] A_R_FIN   = 6'd25;
  localparam logic [UPC_W-1:0] A_R_DIV   = 6'd26;
  localparam logic [UPC_W-1:0] A_R_DO    = 6'd27;
  localparam logic [UPC_W-1:0] A_H0      = 6'd28;
  localparam logic [UPC_W-1:0] A_H1      = 6'd29;
  localparam logic [UPC_W-1:0] A_H2      = 6'd30;
  localparam logic [UPC_W-1:0] A_H_END   = 6'd31;
  localparam logic [UPC_W-1:0] A_H_PD    = 6'd32;
  localparam logic [UPC_W-1:0] A_H_RST   = 6'd33;
  localparam logic [UPC_W-1:0] A_RR      = 6'd34;
  localparam logic [UPC_W-1:0] A_EMIT    = 6'd35;
  localparam logic [UPC_W-1:0] A_EMIT2   = 6'd36;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             ph_we;
    logic [PH_W-1:0]  ph;
    logic             sclk;
    logic             busy;
    logic             done;
    logic [1:0]       st_sel;
    logic [JT_W-1:0]  jt;
    logic [CND_W-1:0] cnd;
    logic [UPC_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic            in_valid;
    logic            dout_low;
    logic            to_zero;
    logic            bits_full;
    logic            samp_end;
    logic            hold_zero;
    logic            div_more;
    logic            out_busy;
    logic            cmd_read;
    logic            cmd_hold;
    logic            cmd_rst;
    logic            idle_hi;
    logic            ph_rst;
    logic [PH_W-1:0] phase;
  } flags_t;

  typedef struct packed {
    logic             sclk;
    logic             done;
    logic [AVG_W-1:0] avg;
    logic [ST_W-1:0]  status;
    logic             busy;
  } res_t;

  function automatic ctrl_t mk(input logic [OP_W-1:0] op, input logic ph_we,
                               input logic [PH_W-1:0] ph, input logic sclk,
                               input logic busy, input logic done,
                               input logic [1:0] st_sel, input logic [JT_W-1:0] jt,
                               input logic [CND_W-1:0] cnd,
                               input logic [UPC_W-1:0] tgt);
    ctrl_t w;
    w.op     = op;
    w.ph_we  = ph_we;
    w.ph     = ph;
    w.sclk   = sclk;
    w.busy   = busy;
    w.done   = done;
    w.st_sel = st_sel;
    w.jt     = jt;
    w.cnd    = cnd;
    w.tgt    = tgt;
    return w;
  endfunction

  // control store: one word per step
  function automatic ctrl_t rom(input logic [UPC_W-1:0] a);
    ctrl_t w;
    case (a)
      A_FETCH:  w = mk(OP_ACCEPT, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IFN, C_IN_VALID, A_FETCH);
      A_DISP:   w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_DISP, C_NONE, A_FETCH);
      // idle: command decode
      A_I0:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_CMD_READ, A_I_READ);
      A_I1:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_CMD_HOLD, A_I_HOLD);
      A_I2:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_IDLE_HI, A_I_HI);
      A_I3:     w = mk(OP_NOP, 1, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_I_HI:   w = mk(OP_NOP, 0, PH_IDLE_LO, 1, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_I_READ: w = mk(OP_START_READ, 1, PH_WAIT, 0, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_I_HOLD: w = mk(OP_LOAD_HOLD, 1, PH_PD_HOLD, 1, 1, 0, SS_KEEP, J_IFN, C_CMD_RST, A_EMIT);
      A_I_RST:  w = mk(OP_NOP, 1, PH_RST_HOLD, 0, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      // wait for data ready
      A_W0:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_DOUT_LOW, A_W_LOW);
      A_W1:     w = mk(OP_DEC_TO, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_NEXT, C_NONE, A_FETCH);
      A_W2:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_TO_ZERO, A_W_FAIL);
      A_W3:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_W_LOW:  w = mk(OP_CLR_WORD, 1, PH_BIT_HI, 0, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_W_FAIL: w = mk(OP_NOP, 1, PH_IDLE_LO, 0, 0, 1, SS_TIMEOUT, J_GOTO, C_NONE, A_EMIT);
      // data bits
      A_B_HI:   w = mk(OP_NOP, 1, PH_BIT_LO, 1, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_B_LO:   w = mk(OP_SHIFT, 0, PH_IDLE_LO, 0, 1, 0, SS_KEEP, J_NEXT, C_NONE, A_FETCH);
      A_B1:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_BITS_FUL, A_B_FULL);
      A_B2:     w = mk(OP_NOP, 1, PH_BIT_HI, 0, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_B_FULL: w = mk(OP_NOP, 1, PH_REL_HI, 0, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      // release pulse, accumulate, average
      A_R_HI:   w = mk(OP_NOP, 1, PH_REL_LO, 1, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_R_LO:   w = mk(OP_ACCUM, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_NEXT, C_NONE, A_FETCH);
      A_R1:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_SAMP_END, A_R_FIN);
      A_R2:     w = mk(OP_LOAD_TO, 1, PH_WAIT, 0, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_R_FIN:  w = mk(OP_DIV_INIT, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_NEXT, C_NONE, A_FETCH);
      A_R_DIV:  w = mk(OP_DIV_STEP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_DIV_MORE, A_R_DIV);
      A_R_DO:   w = mk(OP_DIV_OUT, 1, PH_IDLE_LO, 0, 0, 1, SS_PIN, J_GOTO, C_NONE, A_EMIT);
      // clock held high for reset or power down
      A_H0:     w = mk(OP_DEC_HOLD, 0, PH_IDLE_LO, 1, 0, 0, SS_KEEP, J_NEXT, C_NONE, A_FETCH);
      A_H1:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_HOLD_ZER, A_H_END);
      A_H2:     w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_H_END:  w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_PH_RST, A_H_RST);
      A_H_PD:   w = mk(OP_NOP, 1, PH_IDLE_HI, 0, 0, 1, SS_PIN, J_GOTO, C_NONE, A_EMIT);
      A_H_RST:  w = mk(OP_NOP, 1, PH_RST_REL, 0, 1, 0, SS_KEEP, J_GOTO, C_NONE, A_EMIT);
      A_RR:     w = mk(OP_NOP, 1, PH_IDLE_LO, 0, 0, 1, SS_PIN, J_GOTO, C_NONE, A_EMIT);
      // hand the result to the output register
      A_EMIT:   w = mk(OP_EMIT, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_IF, C_OUT_BUSY, A_EMIT);
      A_EMIT2:  w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_FETCH);
      default:  w = mk(OP_NOP, 0, PH_IDLE_LO, 0, 0, 0, SS_KEEP, J_GOTO, C_NONE, A_FETCH);
    endcase
    return w;
  endfunction

  // entry point of each phase routine
  function automatic logic [UPC_W-1:0] disp(input logic [PH_W-1:0] ph);
    logic [UPC_W-1:0] a;
    case (ph)
      PH_WAIT:     a = A_W0;
      PH_BIT_HI:   a = A_B_HI;
      PH_BIT_LO:   a = A_B_LO;
      PH_REL_HI:   a = A_R_HI;
      PH_REL_LO:   a = A_R_LO;
      PH_RST_HOLD: a = A_H0;
      PH_PD_HOLD:  a = A_H0;
      PH_RST_REL:  a = A_RR;
      default:     a = A_I0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/bsr_seq.sv
`timescale 1ns / 1ps
// microcode sequencer: step counter, control store lookup and jumps
// depends on bsr_pkg
module bsr_seq (
  input  logic           clk,
  input  logic           rst,
  input  bsr_pkg::flags_t flags,
  output bsr_pkg::ctrl_t  ctrl
);

  logic [bsr_pkg::UPC_W-1:0] upc;
  logic [bsr_pkg::UPC_W-1:0] upc_next;
  logic                      cond;

  assign ctrl = bsr_pkg::rom(upc);

  always_comb begin
    case (ctrl.cnd)
      bsr_pkg::C_IN_VALID: cond = flags.in_valid;
      bsr_pkg::C_DOUT_LOW: cond = flags.dout_low;
      bsr_pkg::C_TO_ZERO:  cond = flags.to_zero;
      bsr_pkg::C_BITS_FUL: cond = flags.bits_full;
      bsr_pkg::C_SAMP_END: cond = flags.samp_end;
      bsr_pkg::C_HOLD_ZER: cond = flags.hold_zero;
      bsr_pkg::C_DIV_MORE: cond = flags.div_more;
      bsr_pkg::C_OUT_BUSY: cond = flags.out_busy;
      bsr_pkg::C_CMD_READ: cond = flags.cmd_read;
      bsr_pkg::C_CMD_HOLD: cond = flags.cmd_hold;
      bsr_pkg::C_CMD_RST:  cond = flags.cmd_rst;
      bsr_pkg::C_IDLE_HI:  cond = flags.idle_hi;
      bsr_pkg::C_PH_RST:   cond = flags.ph_rst;
      default:             cond = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.jt)
      bsr_pkg::J_NEXT: upc_next = upc + 1'b1;
      bsr_pkg::J_GOTO: upc_next = ctrl.tgt;
      bsr_pkg::J_IF:   upc_next = cond ? ctrl.tgt : upc + 1'b1;
      bsr_pkg::J_IFN:  upc_next = cond ? upc + 1'b1 : ctrl.tgt;
      bsr_pkg::J_DISP: upc_next = bsr_pkg::disp(flags.phase);
      default:         upc_next = bsr_pkg::A_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= bsr_pkg::A_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

FILE: hw/rtl/bsr_dp.sv
`timescale 1ns / 1ps
// datapath: phase, counters, shift word, sum and bit-serial divider
// depends on bsr_pkg; driven by control words from bsr_seq
module bsr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  bsr_pkg::ctrl_t               ctrl,
  input  logic                         in_valid,
  input  logic                         out_busy,
  input  logic [bsr_pkg::CMD_W-1:0]    command,
  input  logic                         dout_level,
  input  logic [bsr_pkg::CNT_W-1:0]    eff_cnt,
  input  logic [bsr_pkg::TO_W-1:0]     eff_to,
  input  logic [bsr_pkg::HOLD_W-1:0]   eff_hold,
  output bsr_pkg::flags_t              flags,
  output bsr_pkg::res_t                res
);

  logic [bsr_pkg::CMD_W-1:0]       cmd_q;
  logic                            dout_q;
  logic [bsr_pkg::PH_W-1:0]        phase;
  logic [bsr_pkg::TO_W-1:0]        timeout_left;
  logic [bsr_pkg::BIT_CNT_W-1:0]   bit_count;
  logic [bsr_pkg::SAMPLE_BITS-1:0] shift_word;
  logic [bsr_pkg::CNT_W-1:0]       samples_done;
  logic [bsr_pkg::SUM_W-1:0]       code_sum;
  logic [bsr_pkg::HOLD_W-1:0]      hold_left;
  logic [bsr_pkg::CNT_W-1:0]       rem;
  logic [bsr_pkg::DIV_CNT_W-1:0]   div_cnt;

  logic                            accept;
  logic [bsr_pkg::CNT_W:0]         trial;
  logic [bsr_pkg::CNT_W:0]         trial_sub;
  logic                            ge;
  logic [bsr_pkg::SAMPLE_BITS-1:0] word_ob;
  logic [bsr_pkg::SUM_W+bsr_pkg::AVG_W-1:0] quo_ext;

  assign accept    = (ctrl.op == bsr_pkg::OP_ACCEPT) && in_valid;
  assign trial     = {rem, code_sum[bsr_pkg::SUM_W-1]};
  assign ge        = trial >= {1'b0, eff_cnt};
  assign trial_sub = trial - {1'b0, eff_cnt};
  assign word_ob   = shift_word ^ bsr_pkg::WORD_MSB;
  assign quo_ext   = {{bsr_pkg::AVG_W{1'b0}}, code_sum};

  always_comb begin
    flags.in_valid  = in_valid;
    flags.dout_low  = !dout_q;
    flags.to_zero   = timeout_left == '0;
    flags.bits_full = bit_count >= bsr_pkg::BIT_CNT_W'(bsr_pkg::SAMPLE_BITS);
    flags.samp_end  = samples_done >= eff_cnt;
    flags.hold_zero = hold_left == '0;
    flags.div_more  = div_cnt != bsr_pkg::DIV_CNT_W'(1);
    flags.out_busy  = out_busy;
    flags.cmd_read  = cmd_q == bsr_pkg::CMD_READ;
    flags.cmd_hold  = (cmd_q == bsr_pkg::CMD_RESET) || (cmd_q == bsr_pkg::CMD_PDOWN);
    flags.cmd_rst   = cmd_q == bsr_pkg::CMD_RESET;
    flags.idle_hi   = phase == bsr_pkg::PH_IDLE_HI;
    flags.ph_rst    = phase == bsr_pkg::PH_RST_HOLD;
    flags.phase     = phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= bsr_pkg::PH_IDLE_LO;
      timeout_left <= '0;
      bit_count    <= '0;
      shift_word   <= '0;
      samples_done <= '0;
      code_sum     <= '0;
      hold_left    <= '0;
      rem          <= '0;
      div_cnt      <= '0;
    end else begin
      if (ctrl.ph_we) begin
        phase <= ctrl.ph;
      end
      case (ctrl.op)
        bsr_pkg::OP_START_READ: begin
          samples_done <= '0;
          code_sum     <= '0;
          bit_count    <= '0;
          shift_word   <= '0;
          timeout_left <= eff_to;
        end
        bsr_pkg::OP_DEC_TO: begin
          timeout_left <= timeout_left - 1'b1;
        end
        bsr_pkg::OP_CLR_WORD: begin
          bit_count  <= '0;
          shift_word <= '0;
        end
        bsr_pkg::OP_SHIFT: begin
          shift_word <= {shift_word[bsr_pkg::SAMPLE_BITS-2:0], dout_q};
          bit_count  <= bit_count + 1'b1;
        end
        bsr_pkg::OP_ACCUM: begin
          code_sum <= code_sum
                    + {{(bsr_pkg::SUM_W-bsr_pkg::SAMPLE_BITS){1'b0}}, word_ob};
          samples_done <= samples_done + 1'b1;
        end
        bsr_pkg::OP_LOAD_TO: begin
          timeout_left <= eff_to;
        end
        bsr_pkg::OP_LOAD_HOLD: begin
          hold_left <= eff_hold;
        end
        bsr_pkg::OP_DEC_HOLD: begin
          hold_left <= hold_left - 1'b1;
        end
        bsr_pkg::OP_DIV_INIT: begin
          rem     <= '0;
          div_cnt <= bsr_pkg::DIV_CNT_W'(bsr_pkg::SUM_W);
        end
        bsr_pkg::OP_DIV_STEP: begin
          // restoring step: quotient bits shift into the sum register
          rem      <= ge ? trial_sub[bsr_pkg::CNT_W-1:0] : trial[bsr_pkg::CNT_W-1:0];
          code_sum <= {code_sum[bsr_pkg::SUM_W-2:0], ge};
          div_cnt  <= div_cnt - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // request latch and result scratch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= command;
      dout_q     <= dout_level;
      res.sclk   <= 1'b0;
      res.done   <= 1'b0;
      res.avg    <= '0;
      res.status <= bsr_pkg::ST_OK;
      res.busy   <= 1'b0;
    end else begin
      if (ctrl.sclk) begin
        res.sclk <= 1'b1;
      end
      if (ctrl.busy) begin
        res.busy <= 1'b1;
      end
      if (ctrl.done) begin
        res.done <= 1'b1;
      end
      case (ctrl.st_sel)
        bsr_pkg::SS_TIMEOUT: res.status <= bsr_pkg::ST_TIMEOUT;
        bsr_pkg::SS_PIN:     res.status <= dout_q ? bsr_pkg::ST_OK : bsr_pkg::ST_PIN_LOW;
        default:             res.status <= res.status;
      endcase
      if (ctrl.op == bsr_pkg::OP_DIV_OUT) begin
        res.avg <= quo_ext[bsr_pkg::AVG_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/bridge_adc_serial_read_average.sv
`timescale 1ns / 1ps
// bridge adc serial reader with averaging: each request is one serial-clock tick
// requests are taken one at a time: a new one only after the last result is loaded for output
// the last release tick of a read also runs the restoring divide loop of the microprogram,
// one quotient bit per step (SUM_W = 35 steps)
// synchronous reset: registers to defaults, idle with clock low, no clearing pass
// depends on bsr_pkg, bsr_seq, bsr_dp
module bridge_adc_serial_read_average (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsr_pkg::CMD_W-1:0]    command,
  input  logic                         dout_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         sclk_level,
  output logic                         done_res,
  output logic [bsr_pkg::AVG_W-1:0]    average_value,
  output logic [bsr_pkg::ST_W-1:0]     status,
  output logic                         busy_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bsr_pkg::CFG_W-1:0]    cfg_data
);

  logic [bsr_pkg::CNT_W-1:0]  average_count;
  logic [bsr_pkg::TO_W-1:0]   ready_timeout_ticks;
  logic [bsr_pkg::HOLD_W-1:0] hold_ticks;
  logic [bsr_pkg::CNT_W-1:0]  eff_cnt;
  logic [bsr_pkg::TO_W-1:0]   eff_to;
  logic [bsr_pkg::HOLD_W-1:0] eff_hold;

  bsr_pkg::ctrl_t  ctrl;
  bsr_pkg::flags_t flags;
  bsr_pkg::res_t   res;
  logic            out_busy;
  logic            load;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.op == bsr_pkg::OP_ACCEPT;
  assign out_busy  = out_valid && !out_ready;
  assign load      = (ctrl.op == bsr_pkg::OP_EMIT) && !out_busy;

  always_comb begin
    if (average_count == '0) begin
      eff_cnt = bsr_pkg::CNT_W'(1);
    end else if (average_count > bsr_pkg::CNT_MAX) begin
      eff_cnt = bsr_pkg::CNT_MAX;
    end else begin
      eff_cnt = average_count;
    end
    eff_to   = (ready_timeout_ticks == '0) ? bsr_pkg::TO_W'(1) : ready_timeout_ticks;
    eff_hold = (hold_ticks == '0) ? bsr_pkg::HOLD_W'(1) : hold_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_count       <= bsr_pkg::CNT_RESET;
      ready_timeout_ticks <= bsr_pkg::TO_RESET;
      hold_ticks          <= bsr_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsr_pkg::REG_AVERAGE_COUNT: average_count <= cfg_data[bsr_pkg::CNT_W-1:0];
        bsr_pkg::REG_READY_TIMEOUT: ready_timeout_ticks <= cfg_data[bsr_pkg::TO_W-1:0];
        bsr_pkg::REG_HOLD_TICKS:    hold_ticks <= cfg_data[bsr_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bsr_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  bsr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_valid   (in_valid),
    .out_busy   (out_busy),
    .command    (command),
    .dout_level (dout_level),
    .eff_cnt    (eff_cnt),
    .eff_to     (eff_to),
    .eff_hold   (eff_hold),
    .flags      (flags),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sclk_level    <= res.sclk;
      done_res      <= res.done;
      average_value <= res.avg;
      status        <= res.status;
      busy_res      <= res.busy;
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken before the first finished");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("result marked done and busy");

  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (status == bsr_pkg::ST_OK))
    else $error("status without done");

  a_avg_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (average_value == '0))
    else $error("average without done");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for bridge_adc_serial_read_average: tick requests checked against a behavioral
// predictor of the reader, with random idling and back-pressure on both sides
// depends on bsr_pkg and the rtl of the block
module tb_top;
  import bsr_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_TICKS = 600;
  localparam int DRAIN_CYCLES = 60;

  // data word choice for a conversion
  localparam int WORD_ANY  = 0;
  localparam int WORD_TOP  = 1;
  localparam int WORD_ZERO = 2;
  localparam int NO_FAIL   = -1;
  localparam int PIN_ANY   = -1;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     command;
  logic                 dout_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 sclk_level;
  logic                 done_res;
  logic [AVG_W-1:0]     average_value;
  logic [ST_W-1:0]      status;
  logic                 busy_res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bridge_adc_serial_read_average dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .dout_level(dout_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sclk_level(sclk_level),
    .done_res(done_res),
    .average_value(average_value),
    .status(status),
    .busy_res(busy_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // reader state as predicted by the testbench
  logic [PH_W-1:0]        rd_phase;
  logic [TO_W-1:0]        rd_timeout_left;
  logic [5:0]             rd_bits;
  logic [SAMPLE_BITS-1:0] rd_word;
  logic [CNT_W-1:0]       rd_samples;
  logic [SUM_W-1:0]       rd_sum;
  logic [HOLD_W-1:0]      rd_hold_left;
  logic [CNT_W-1:0]       reg_count;
  logic [TO_W-1:0]        reg_timeout;
  logic [HOLD_W-1:0]      reg_hold;

  res_t tick_results_q[$];
  res_t want;
  int   errors;
  int   ticks_sent;
  int   cycles;
  int   hold_off_req;
  bit   quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bridge_adc_serial_read_average] ERROR");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] conv_per_read();
    if (reg_count == '0) return CNT_W'(1);
    if (reg_count > CNT_W'(1024)) return CNT_W'(1024);
    return reg_count;
  endfunction

  function automatic logic [TO_W-1:0] timeout_reload();
    return (reg_timeout == '0) ? TO_W'(1) : reg_timeout;
  endfunction

  function automatic logic [HOLD_W-1:0] hold_reload();
    return (reg_hold == '0) ? HOLD_W'(1) : reg_hold;
  endfunction

  // advances the predicted reader by one tick and returns the result of that tick
  function automatic res_t predict_tick(input logic [CMD_W-1:0] cmd, input logic pin);
    res_t r;
    logic [SUM_W-1:0] n;
    r = '0;
    n = SUM_W'(conv_per_read());
    case (rd_phase)
      PH_WAIT: begin
        if (!pin) begin
          rd_bits = '0;
          rd_word = '0;
          rd_phase = PH_BIT_HI;
          r.busy = 1'b1;
        end else begin
          rd_timeout_left = rd_timeout_left - 1'b1;
          if (rd_timeout_left == '0) begin
            r.done = 1'b1;
            r.status = ST_TIMEOUT;
            rd_phase = PH_IDLE_LO;
          end else begin
            r.busy = 1'b1;
          end
        end
      end
      PH_BIT_HI: begin
        r.sclk = 1'b1;
        r.busy = 1'b1;
        rd_phase = PH_BIT_LO;
      end
      PH_BIT_LO: begin
        rd_word = {rd_word[SAMPLE_BITS-2:0], pin};
        rd_bits = rd_bits + 1'b1;
        r.busy = 1'b1;
        rd_phase = (rd_bits >= SAMPLE_BITS) ? PH_REL_HI : PH_BIT_HI;
      end
      PH_REL_HI: begin
        r.sclk = 1'b1;
        r.busy = 1'b1;
        rd_phase = PH_REL_LO;
      end
      PH_REL_LO: begin
        rd_sum = rd_sum + SUM_W'(rd_word ^ WORD_MSB);
        rd_samples = rd_samples + 1'b1;
        if (rd_samples >= conv_per_read()) begin
          r.avg = AVG_W'(rd_sum / n);
          r.done = 1'b1;
          r.status = pin ? ST_OK : ST_PIN_LOW;
          rd_phase = PH_IDLE_LO;
        end else begin
          rd_timeout_left = timeout_reload();
          r.busy = 1'b1;
          rd_phase = PH_WAIT;
        end
      end
      PH_RST_HOLD, PH_PD_HOLD: begin
        r.sclk = 1'b1;
        rd_hold_left = rd_hold_left - 1'b1;
        if (rd_hold_left != '0) begin
          r.busy = 1'b1;
        end else if (rd_phase == PH_RST_HOLD) begin
          r.busy = 1'b1;
          rd_phase = PH_RST_REL;
        end else begin
          r.done = 1'b1;
          r.status = pin ? ST_OK : ST_PIN_LOW;
          rd_phase = PH_IDLE_HI;
        end
      end
      PH_RST_REL: begin
        r.done = 1'b1;
        r.status = pin ? ST_OK : ST_PIN_LOW;
        rd_phase = PH_IDLE_LO;
      end
      default: begin
        if (rd_phase != PH_IDLE_HI) rd_phase = PH_IDLE_LO;
        r.sclk = (rd_phase == PH_IDLE_HI);
        if (cmd == CMD_READ) begin
          r.sclk = 1'b0;
          r.busy = 1'b1;
          rd_samples = '0;
          rd_sum = '0;
          rd_bits = '0;
          rd_word = '0;
          rd_timeout_left = timeout_reload();
          rd_phase = PH_WAIT;
        end else if (cmd == CMD_RESET || cmd == CMD_PDOWN) begin
          r.sclk = 1'b1;
          r.busy = 1'b1;
          rd_hold_left = hold_reload();
          rd_phase = (cmd == CMD_RESET) ? PH_RST_HOLD : PH_PD_HOLD;
        end
      end
    endcase
    return r;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_word(input int kind);
    case (kind)
      WORD_TOP:  return ~WORD_MSB;
      WORD_ZERO: return WORD_MSB;
      default: begin
        case ($urandom_range(0, 7))
          0: return ~WORD_MSB;
          1: return WORD_MSB;
          2: return '1;
          3: return '0;
          default: return SAMPLE_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  // random bits above the register width, which the block must drop
  function automatic logic [CFG_W-1:0] with_noise(input logic [CFG_W-1:0] v, input int w);
    logic [CFG_W-1:0] m;
    m = {CFG_W{1'b1}} << w;
    return (CFG_W'($urandom) & m) | (v & ~m);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // sink side: random stalls, or a long hold-off when one is requested
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (tick_results_q.size() == 0) begin
        $display("%0t: result with no request pending: sclk=%0b done=%0b avg=%0h st=%0d busy=%0b",
                 $time, sclk_level, done_res, average_value, status, busy_res);
        errors++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("sclk_level", 32'(want.sclk), 32'(sclk_level));
        check_field("done_res", 32'(want.done), 32'(done_res));
        check_field("average_value", 32'(want.avg), 32'(average_value));
        check_field("status", 32'(want.status), 32'(status));
        check_field("busy_res", 32'(want.busy), 32'(busy_res));
      end
    end
  end

  // called right after a falling edge; returns right after one
  task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic pin);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    dout_level = pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_results_q.push_back(predict_tick(cmd, pin));
    ticks_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_results_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_AVERAGE_COUNT: reg_count = data[CNT_W-1:0];
      REG_READY_TIMEOUT: reg_timeout = data[TO_W-1:0];
      REG_HOLD_TICKS:    reg_hold = data[HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // issues a command, then keeps ticking until the predicted reader is idle again;
  // the pin drops after up to max_wait high ticks, except on conversion fail_conv
  // where it stays high until the ready timeout hits
  task automatic run_op(input logic [CMD_W-1:0] cmd, input int max_wait, input int word_kind,
                        input int fail_conv, input int final_pin);
    int wait_left;
    int conv;
    logic [SAMPLE_BITS-1:0] word;
    logic pin;
    wait_left = $urandom_range(0, max_wait);
    conv = 0;
    word = '0;
    send_tick(cmd, 1'($urandom_range(0, 1)));
    while (rd_phase != PH_IDLE_LO && rd_phase != PH_IDLE_HI) begin
      pin = 1'($urandom_range(0, 1));
      case (rd_phase)
        PH_WAIT: begin
          if (conv == fail_conv) begin
            pin = 1'b1;
          end else if (wait_left > 0 && rd_timeout_left > 1) begin
            pin = 1'b1;
            wait_left--;
          end else begin
            pin = 1'b0;
            conv++;
            wait_left = $urandom_range(0, max_wait);
            word = pick_word(word_kind);
          end
        end
        PH_BIT_LO: pin = word[SAMPLE_BITS-1-rd_bits];
        PH_REL_LO: begin
          if (final_pin != PIN_ANY && rd_samples + 1 >= conv_per_read()) pin = final_pin[0];
        end
        default: ;
      endcase
      // commands during an operation must be ignored
      send_tick(CMD_W'($urandom_range(0, 3)), pin);
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_TICK, 1'b1);
  endtask

  // reset values of all three registers
  task automatic test_default_settings();
    run_op(CMD_READ, 3, WORD_ANY, NO_FAIL, 1);
    run_op(CMD_RESET, 0, WORD_ANY, NO_FAIL, PIN_ANY);
    run_op(CMD_PDOWN, 0, WORD_ANY, NO_FAIL, PIN_ANY);
    // clock stays high while idle after power down
    send_tick(CMD_TICK, 1'b0);
    send_tick(CMD_TICK, 1'b1);
    run_op(CMD_READ, 0, WORD_TOP, NO_FAIL, 0);
  endtask

  task automatic test_code_extremes();
    write_reg(REG_AVERAGE_COUNT, with_noise(CFG_W'(1), CNT_W));
    run_op(CMD_READ, 0, WORD_TOP, NO_FAIL, 1);
    run_op(CMD_READ, 0, WORD_ZERO, NO_FAIL, 1);
    run_op(CMD_READ, 2, WORD_ANY, NO_FAIL, 0);
    write_reg(REG_AVERAGE_COUNT, with_noise(CFG_W'(2), CNT_W));
    run_op(CMD_READ, 1, WORD_TOP, NO_FAIL, 1);
  endtask

  task automatic test_count_limits();
    write_reg(REG_AVERAGE_COUNT, CFG_W'(0));
    run_op(CMD_READ, 1, WORD_ANY, NO_FAIL, 1);
    // above the limit: clamped; the read is cut short by a ready timeout
    write_reg(REG_AVERAGE_COUNT, with_noise(CFG_W'(2047), CNT_W));
    write_reg(REG_READY_TIMEOUT, CFG_W'(5));
    run_op(CMD_READ, 2, WORD_TOP, 3, PIN_ANY);
    write_reg(REG_AVERAGE_COUNT, with_noise(CFG_W'(1024), CNT_W));
    run_op(CMD_READ, 2, WORD_ANY, 2, PIN_ANY);
  endtask

  task automatic test_timeout_limits();
    write_reg(REG_AVERAGE_COUNT, CFG_W'(2));
    write_reg(REG_READY_TIMEOUT, CFG_W'(0));
    run_op(CMD_READ, 0, WORD_ANY, 0, PIN_ANY);
    run_op(CMD_READ, 0, WORD_ANY, NO_FAIL, 1);
    write_reg(REG_READY_TIMEOUT, CFG_W'(1));
    run_op(CMD_READ, 0, WORD_ANY, 1, PIN_ANY);
    write_reg(REG_READY_TIMEOUT, CFG_W'(33554431));
    run_op(CMD_READ, 20, WORD_ANY, NO_FAIL, 0);
  endtask

  task automatic test_hold_limits();
    write_reg(REG_HOLD_TICKS, with_noise(CFG_W'(0), HOLD_W));
    run_op(CMD_RESET, 0, WORD_ANY, NO_FAIL, PIN_ANY);
    run_op(CMD_PDOWN, 0, WORD_ANY, NO_FAIL, PIN_ANY);
    write_reg(REG_HOLD_TICKS, with_noise(CFG_W'(1), HOLD_W));
    run_op(CMD_RESET, 0, WORD_ANY, NO_FAIL, PIN_ANY);
    write_reg(REG_HOLD_TICKS, with_noise(CFG_W'(65535), HOLD_W));
    run_op(CMD_READ, 2, WORD_ANY, NO_FAIL, 1);
    // unused register index must change nothing
    write_reg(IDX_W'(3), CFG_W'($urandom));
    run_op(CMD_READ, 2, WORD_ANY, NO_FAIL, 1);
  endtask

  task automatic test_backpressure();
    write_reg(REG_HOLD_TICKS, CFG_W'(3));
    write_reg(REG_READY_TIMEOUT, CFG_W'(40));
    hold_off_req = 400;
    run_op(CMD_READ, 4, WORD_ANY, NO_FAIL, PIN_ANY);
    // sender stops until everything is back
    wait_drained();
    run_op(CMD_PDOWN, 0, WORD_ANY, NO_FAIL, PIN_ANY);
    hold_off_req = 250;
    run_op(CMD_RESET, 0, WORD_ANY, NO_FAIL, PIN_ANY);
  endtask

  task automatic test_random();
    int stop_at;
    int r;
    int n;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      n = (r < 6) ? 1 : (r < 9) ? $urandom_range(2, 3) : $urandom_range(0, 6);
      write_reg(REG_AVERAGE_COUNT, with_noise(CFG_W'(n), CNT_W));
      r = $urandom_range(0, 9);
      n = (r < 6) ? $urandom_range(1, 12) : (r < 8) ? 0 : $urandom;
      write_reg(REG_READY_TIMEOUT, CFG_W'(n));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      write_reg(REG_HOLD_TICKS, with_noise(CFG_W'(n), HOLD_W));
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 11);
        if (r < 7) begin
          run_op(CMD_READ, $urandom_range(0, 6), WORD_ANY, NO_FAIL, PIN_ANY);
        end else if (r == 7) begin
          // broken read if the timeout is short: pin stays high on some conversion
          if (timeout_reload() <= 16)
            run_op(CMD_READ, 2, WORD_ANY, $urandom_range(0, conv_per_read() - 1), PIN_ANY);
          else
            run_op(CMD_READ, 2, WORD_ANY, NO_FAIL, PIN_ANY);
        end else if (r == 8) begin
          run_op(CMD_RESET, 0, WORD_ANY, NO_FAIL, PIN_ANY);
        end else if (r == 9) begin
          run_op(CMD_PDOWN, 0, WORD_ANY, NO_FAIL, PIN_ANY);
        end else begin
          repeat ($urandom_range(1, 5)) send_tick(CMD_TICK, 1'($urandom_range(0, 1)));
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_TICK;
    dout_level = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_AVERAGE_COUNT;
    cfg_data = '0;
    errors = 0;
    ticks_sent = 0;
    cycles = 0;
    hold_off_req = 0;
    quiet = 1'b0;
    reg_count = 11'd1;
    reg_timeout = 25'd23232323;
    reg_hold = 16'd52;
    rd_phase = PH_IDLE_LO;
    rd_timeout_left = '0;
    rd_bits = '0;
    rd_word = '0;
    rd_samples = '0;
    rd_sum = '0;
    rd_hold_left = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_ticks();
    test_default_settings();
    test_code_extremes();
    test_count_limits();
    test_timeout_limits();
    test_hold_limits();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[bridge_adc_serial_read_average] OK");
    end else begin
      $display("[bridge_adc_serial_read_average] ERROR");
    end
    $finish;
  end

endmodule
